// File: rtl/bcc_pkg.sv
`timescale 1ns / 1ps

package bcc_pkg;

  // Number of cache slots and the width of a slot number.
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Fixed field widths of the channels.
  localparam int TAG_W      = 24;
  localparam int ACT_W      = 2;
  localparam int SLOT_OUT_W = 4;

  // Action codes of a request item.
  localparam logic [ACT_W-1:0] ACT_GET   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MARK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

  // Control from the sequencer to the slot store.
  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              tag_we;
    logic [SLOT_W-1:0] tag_waddr;
    logic [TAG_W-1:0]  tag_wdata;
    logic              dirty_we;
    logic [SLOT_W-1:0] dirty_addr;
    logic              dirty_val;
  } slot_ctrl_t;

  // One response item as held in the output register.
  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  hit;
    logic                  writeback_valid;
    logic [TAG_W-1:0]      writeback_block;
    logic                  read_valid;
    logic [TAG_W-1:0]      read_block;
    logic                  last;
  } result_t;

endpackage

// File: rtl/bcc_in_if.sv
`timescale 1ns / 1ps

interface bcc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bcc_pkg::ACT_W-1:0]   action;
  logic [bcc_pkg::TAG_W-1:0]   block_number;
  logic [3:0]                  target_slot;
  logic                        dirty_value;

  modport source (output valid, output action, output block_number, output target_slot,
                  output dirty_value, input ready);
  modport sink (input valid, input action, input block_number, input target_slot,
                input dirty_value, output ready);
endinterface

// File: rtl/bcc_out_if.sv
`timescale 1ns / 1ps

interface bcc_out_if;
  logic                             valid;
  logic                             ready;
  logic [bcc_pkg::SLOT_OUT_W-1:0]   slot;
  logic                             hit;
  logic                             writeback_valid;
  logic [bcc_pkg::TAG_W-1:0]        writeback_block;
  logic                             read_valid;
  logic [bcc_pkg::TAG_W-1:0]        read_block;
  logic                             last;

  modport source (output valid, output slot, output hit, output writeback_valid,
                  output writeback_block, output read_valid, output read_block,
                  output last, input ready);
  modport sink (input valid, input slot, input hit, input writeback_valid,
                input writeback_block, input read_valid, input read_block,
                input last, output ready);
endinterface

// File: rtl/bcc_ram.sv
`timescale 1ns / 1ps

module bcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bcc_slot_store.sv
`timescale 1ns / 1ps

module bcc_slot_store (
  input  logic                            clk,
  input  logic                            rst,
  input  bcc_pkg::slot_ctrl_t             ctrl,
  output logic [bcc_pkg::TAG_W-1:0]       tag_rd,
  output logic [bcc_pkg::SLOTS-1:0]       dirty
);

  logic [bcc_pkg::SLOTS-1:0]  tag_valid;
  logic [bcc_pkg::SLOT_W-1:0] rd_addr_q;
  logic [bcc_pkg::TAG_W-1:0]  ram_rdata;

  bcc_ram #(
    .WIDTH (bcc_pkg::TAG_W),
    .DEPTH (bcc_pkg::SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ctrl.tag_we),
    .waddr (ctrl.tag_waddr),
    .wdata (ctrl.tag_wdata),
    .raddr (ctrl.rd_addr),
    .rdata (ram_rdata)
  );

  // A slot never retagged still holds its own number, as after reset.
  assign tag_rd = tag_valid[rd_addr_q] ? ram_rdata : bcc_pkg::TAG_W'(rd_addr_q);

  always_ff @(posedge clk) begin
    rd_addr_q <= ctrl.rd_addr;
    if (rst) begin
      tag_valid <= '0;
      dirty     <= '0;
    end else begin
      if (ctrl.tag_we) begin
        tag_valid[ctrl.tag_waddr] <= 1'b1;
      end
      if (ctrl.dirty_we) begin
        dirty[ctrl.dirty_addr] <= ctrl.dirty_val;
      end
    end
  end

endmodule

// File: rtl/bcc_sequencer.sv
`timescale 1ns / 1ps

module bcc_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  bcc_in_if.sink                      request,
  bcc_out_if.source                   response,
  output bcc_pkg::slot_ctrl_t         ctrl,
  input  logic [bcc_pkg::TAG_W-1:0]   tag_rd,
  input  logic [bcc_pkg::SLOTS-1:0]   dirty
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_GREAD = 7'b0000010,
    S_GCMP  = 7'b0000100,
    S_VREAD = 7'b0001000,
    S_VEMIT = 7'b0010000,
    S_FSCAN = 7'b0100000,
    S_FEMIT = 7'b1000000
  } state_t;

  localparam logic [bcc_pkg::SLOT_W-1:0] LAST_SLOT = bcc_pkg::SLOT_W'(bcc_pkg::SLOTS - 1);

  state_t                     state;
  logic [bcc_pkg::SLOT_W-1:0] idx;
  logic [bcc_pkg::SLOT_W-1:0] victim;
  logic [bcc_pkg::TAG_W-1:0]  num_q;
  bcc_pkg::result_t           resp;
  logic                       resp_valid;

  logic accept;
  logic out_free;
  logic match;
  logic higher_dirty;

  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;
  assign out_free      = !resp_valid || response.ready;

  // The one tag comparator, used once per slot during a lookup.
  assign match = (tag_rd == num_q);

  always_comb begin
    higher_dirty = 1'b0;
    for (int j = 0; j < bcc_pkg::SLOTS; j++) begin
      if (dirty[j] && (j > int'(idx))) begin
        higher_dirty = 1'b1;
      end
    end
  end

  always_comb begin
    ctrl = '0;
    ctrl.rd_addr = ((state == S_VREAD) || (state == S_VEMIT)) ? victim : idx;
    if (accept && (request.action == bcc_pkg::ACT_MARK) &&
        (int'(request.target_slot) < bcc_pkg::SLOTS)) begin
      ctrl.dirty_we   = 1'b1;
      ctrl.dirty_addr = bcc_pkg::SLOT_W'(request.target_slot);
      ctrl.dirty_val  = request.dirty_value;
    end else if ((state == S_VEMIT) && out_free) begin
      ctrl.tag_we     = 1'b1;
      ctrl.tag_waddr  = victim;
      ctrl.tag_wdata  = num_q;
      ctrl.dirty_we   = 1'b1;
      ctrl.dirty_addr = victim;
      ctrl.dirty_val  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      resp_valid <= 1'b0;
      victim     <= '0;
      idx        <= '0;
    end else begin
      if (resp_valid && response.ready) begin
        resp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx   <= '0;
            num_q <= request.block_number;
            case (request.action)
              bcc_pkg::ACT_GET:   state <= S_GREAD;
              bcc_pkg::ACT_FLUSH: state <= S_FSCAN;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_GREAD: state <= S_GCMP;
        S_GCMP: begin
          if (match) begin
            if (out_free) begin
              resp.slot            <= bcc_pkg::SLOT_OUT_W'(idx);
              resp.hit             <= 1'b1;
              resp.writeback_valid <= dirty[idx];
              resp.writeback_block <= dirty[idx] ? tag_rd : '0;
              resp.read_valid      <= 1'b0;
              resp.read_block      <= '0;
              resp.last            <= 1'b1;
              resp_valid           <= 1'b1;
              state                <= S_IDLE;
            end
          end else if (idx == LAST_SLOT) begin
            state <= S_VREAD;
          end else begin
            idx   <= idx + bcc_pkg::SLOT_W'(1);
            state <= S_GREAD;
          end
        end
        S_VREAD: state <= S_VEMIT;
        S_VEMIT: begin
          if (out_free) begin
            resp.slot            <= bcc_pkg::SLOT_OUT_W'(victim);
            resp.hit             <= 1'b0;
            resp.writeback_valid <= dirty[victim];
            resp.writeback_block <= dirty[victim] ? tag_rd : '0;
            resp.read_valid      <= 1'b1;
            resp.read_block      <= num_q;
            resp.last            <= 1'b1;
            resp_valid           <= 1'b1;
            victim <= (victim == LAST_SLOT) ? '0 : victim + bcc_pkg::SLOT_W'(1);
            state  <= S_IDLE;
          end
        end
        S_FSCAN: begin
          if (dirty[idx]) begin
            state <= S_FEMIT;
          end else if (idx == LAST_SLOT) begin
            // Nothing was dirty: a single empty closing item.
            if (out_free) begin
              resp.slot            <= '0;
              resp.hit             <= 1'b0;
              resp.writeback_valid <= 1'b0;
              resp.writeback_block <= '0;
              resp.read_valid      <= 1'b0;
              resp.read_block      <= '0;
              resp.last            <= 1'b1;
              resp_valid           <= 1'b1;
              state                <= S_IDLE;
            end
          end else begin
            idx <= idx + bcc_pkg::SLOT_W'(1);
          end
        end
        S_FEMIT: begin
          if (out_free) begin
            resp.slot            <= bcc_pkg::SLOT_OUT_W'(idx);
            resp.hit             <= 1'b0;
            resp.writeback_valid <= 1'b1;
            resp.writeback_block <= tag_rd;
            resp.read_valid      <= 1'b0;
            resp.read_block      <= '0;
            resp.last            <= !higher_dirty;
            resp_valid           <= 1'b1;
            if (higher_dirty) begin
              idx   <= idx + bcc_pkg::SLOT_W'(1);
              state <= S_FSCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign response.valid           = resp_valid;
  assign response.slot            = resp.slot;
  assign response.hit             = resp.hit;
  assign response.writeback_valid = resp.writeback_valid;
  assign response.writeback_block = resp.writeback_block;
  assign response.read_valid      = resp.read_valid;
  assign response.read_block      = resp.read_block;
  assign response.last            = resp.last;

  a_hit_no_read: assert property (@(posedge clk) disable iff (rst)
    response.valid |-> !(response.hit && response.read_valid))
    else $error("hit item also requests a read");

  a_wb_block_zero: assert property (@(posedge clk) disable iff (rst)
    (response.valid && !response.writeback_valid) |-> (response.writeback_block == '0))
    else $error("write-back block not zero without write-back");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (response.valid && !response.hit && !response.read_valid && !response.writeback_valid)
      |-> response.last)
    else $error("empty flush item without closing mark");

  a_victim_moves: assert property (@(posedge clk) disable iff (rst)
    ((state == S_VEMIT) && out_free) |=> (victim != $past(victim)))
    else $error("victim pointer did not advance after a miss");

endmodule

// File: rtl/block_cache_controller_unit.sv
`timescale 1ns / 1ps

// Tag and replacement controller for a fully associative write-back block cache of
// bcc_pkg::SLOTS slots, with a round-robin victim pointer. A request item either looks
// up a block (get), sets one slot's dirty mark (mark) or lists every dirty slot
// (flush); response items report the slot, a hit flag, any write-back and read that
// storage must perform, and a last flag on the final item of each get or flush. A
// miss clears the victim's dirty mark as it retags it; other write-backs leave the
// marks set. Requests are taken one at a time: the controller is ready only while it
// is idle, though it takes a new request while the previous response item still
// waits in the output register. All tags sit in a RAM with one write and one read
// port and a registered read and are checked by one shared comparator, one slot at
// a time: a get reads and then compares each slot until a hit, a miss then reads
// the victim's tag and emits, and a flush steps slot by slot and emits one item per
// dirty slot up to the last dirty one; a mark is taken without a response item.
// A response stall holds the controller until the output register frees.
module block_cache_controller_unit (
  input  logic      clk,
  input  logic      rst,
  bcc_in_if.sink    request,
  bcc_out_if.source response
);

  // Control from the sequencer to the tag RAM and dirty marks.
  bcc_pkg::slot_ctrl_t              ctrl;
  // Tag of the slot addressed in the previous cycle.
  logic [bcc_pkg::TAG_W-1:0]        tag_rd;
  // One dirty mark per slot, kept in flip-flops.
  logic [bcc_pkg::SLOTS-1:0]        dirty;

  // The sequencer steps through the slots and builds every response item.
  bcc_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response),
    .ctrl     (ctrl),
    .tag_rd   (tag_rd),
    .dirty    (dirty)
  );

  // The slot store holds the tags, their reset-value valid bits and the dirty marks.
  bcc_slot_store u_slot_store (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .tag_rd (tag_rd),
    .dirty  (dirty)
  );

endmodule
